FILE: hw/rtl/tpsd_pkg.sv
// Shared constants, types and helpers for the TGA pixel stream decoder.
package tpsd_pkg;

    localparam logic [7:0] TYPE_CMAP_RAW = 8'd1;
    localparam logic [7:0] TYPE_TRUE_RAW = 8'd2;
    localparam logic [7:0] TYPE_CMAP_RLE = 8'd9;
    localparam logic [7:0] TYPE_TRUE_RLE = 8'd10;

    localparam logic [7:0] DEPTH_8  = 8'd8;
    localparam logic [7:0] DEPTH_24 = 8'd24;
    localparam logic [7:0] DEPTH_32 = 8'd32;

    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    localparam logic [1:0] CFG_IMAGE_TYPE  = 2'd0;
    localparam logic [1:0] CFG_PIXEL_DEPTH = 2'd1;
    localparam logic [1:0] CFG_PIXEL_COUNT = 2'd2;

    localparam logic KIND_PIXEL   = 1'b0;
    localparam logic KIND_PALETTE = 1'b1;

    localparam logic [2:0] BPP_NONE = 3'd0;
    localparam logic [2:0] BPP_1    = 3'd1;
    localparam logic [2:0] BPP_3    = 3'd3;
    localparam logic [2:0] BPP_4    = 3'd4;

    // palette access from the decode stage
    typedef struct packed {
        logic        wr_en;
        logic [7:0]  wr_index;
        logic [23:0] wr_value;
        logic        rd_en;
        logic [7:0]  rd_index;
    } pal_req_t;

    // registered palette read, zero for unwritten or out-of-range entries
    typedef struct packed {
        logic [23:0] value;
    } pal_rsp_t;

    // bytes per pixel for a supported type/depth pair, BPP_NONE otherwise
    function automatic logic [2:0] bytes_per_pixel(input logic [7:0] img_type,
                                                   input logic [7:0] depth);
        logic d8;
        logic d24;
        logic d32;
        logic ok;
        d8  = (depth == DEPTH_8);
        d24 = (depth == DEPTH_24);
        d32 = (depth == DEPTH_32);
        case (img_type)
            TYPE_CMAP_RAW: ok = d8;
            TYPE_TRUE_RAW: ok = d24 | d32;
            TYPE_CMAP_RLE,
            TYPE_TRUE_RLE: ok = d8 | d24 | d32;
            default:       ok = 1'b0;
        endcase
        if (!ok) begin
            return BPP_NONE;
        end
        return d8 ? BPP_1 : (d24 ? BPP_3 : BPP_4);
    endfunction

endpackage

FILE: hw/rtl/tga_pixel_stream_decoder_unit.sv
// Top level of the TGA pixel stream decoder (raw/RLE, palette and true color).
//
//  channel   | ports                              | moves
//  ----------+------------------------------------+---------------------------------
//  input     | s_valid / s_ready, s_* fields      | one byte or palette-write request
//  result    | m_valid / m_ready, m_* fields      | one decoded pixel (with repeat)
//  config    | cfg_wr_en, cfg_index, cfg_wr_data  | register write, no handshake
//
// Cycles: one request per clock while s_ready is high. The last byte of a
// pixel is registered into stage 1 along with the synchronous palette read,
// then into the output register. Reset leaves the palette reading zero at
// once (valid bits per entry). A held output stalls the request in stage 1,
// and s_ready drops only while both that stage and the output are occupied.
module tga_pixel_stream_decoder_unit #(
    parameter int PALETTE_ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_wr_data,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [7:0]  s_data_byte,
    input  logic [7:0]  s_palette_index,
    input  logic [23:0] s_palette_value,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_red,
    output logic [7:0]  m_green,
    output logic [7:0]  m_blue,
    output logic [7:0]  m_alpha,
    output logic [7:0]  m_color_index,
    output logic [7:0]  m_repeat_res,
    output logic        m_last_pixel
);
    import tpsd_pkg::*;

    // ---------------- configuration registers ----------------
    logic [7:0]  image_type_reg,  image_type_next;
    logic [7:0]  pixel_depth_reg, pixel_depth_next;
    logic [31:0] pixel_count_reg, pixel_count_next;

    // ---------------- packet / pixel parse state ----------------
    logic        expect_header_reg, expect_header_next;
    logic        run_packet_reg,    run_packet_next;
    logic [7:0]  packet_left_reg,   packet_left_next;
    logic [1:0]  byte_pos_reg,      byte_pos_next;
    logic [23:0] colour_reg,        colour_next;
    logic [31:0] pixels_left_reg,   pixels_left_next;

    // ---------------- stage 1: waits for the palette read ----------------
    logic        s1_vld_reg,     s1_vld_next;
    logic        s1_use_pal_reg;
    logic [23:0] s1_rgb_reg;     // {red, green, blue} for true-color pixels
    logic [7:0]  s1_alpha_reg;
    logic [7:0]  s1_cidx_reg;
    logic [7:0]  s1_rep_reg;
    logic        s1_last_reg;

    // ---------------- output register ----------------
    logic        m_valid_reg, m_valid_next;
    logic [7:0]  m_red_reg, m_green_reg, m_blue_reg, m_alpha_reg;
    logic [7:0]  m_cidx_reg, m_rep_reg;
    logic        m_last_reg;

    // ---------------- decode-stage signals ----------------
    logic        s_accept;
    logic        pix_req;
    logic        out_free;
    logic        s1_move;
    logic [2:0]  bpp;
    logic        rle;
    logic        active;
    logic        header_byte;
    logic [2:0]  pos_plus;
    logic        gather_byte;
    logic        emit;
    logic [7:0]  run_rep;
    logic [7:0]  rep;
    logic        last;
    logic [23:0] pix_rgb;
    logic [7:0]  pix_alpha;
    logic [23:0] full_colour;
    logic        cfg_hit;

    pal_req_t    pal_req;
    pal_rsp_t    pal_rsp;

    // A request enters whenever stage 1 is empty or drains this cycle.
    assign out_free = !m_valid_reg || m_ready;
    assign s1_move  = s1_vld_reg && out_free;
    assign s_ready  = !s1_vld_reg || out_free;
    assign s_accept = s_valid && s_ready;
    assign pix_req  = s_accept && (s_kind == KIND_PIXEL);

    assign bpp    = bytes_per_pixel(image_type_reg, pixel_depth_reg);
    assign rle    = (image_type_reg >= TYPE_CMAP_RLE);
    // dead pair or finished image: bytes fall on the floor
    assign active = pix_req && (bpp != BPP_NONE) && (pixels_left_reg != 32'd0);

    assign header_byte = active && rle && expect_header_reg;
    assign pos_plus    = {1'b0, byte_pos_reg} + 3'd1;
    assign gather_byte = active && !header_byte && (pos_plus < bpp);
    assign emit        = active && !header_byte && !(pos_plus < bpp);

    // Run repeat is clipped to what is left of the image.
    assign run_rep = (32'(packet_left_reg) < pixels_left_reg) ? packet_left_reg
                                                              : pixels_left_reg[7:0];
    assign rep  = (rle && run_packet_reg) ? run_rep : 8'd1;
    assign last = (pixels_left_reg == 32'(rep));

    // True-color assembly: bytes arrive B, G, R (, A).
    assign full_colour = (bpp == BPP_3) ? {s_data_byte, colour_reg[15:0]} : colour_reg;
    assign pix_rgb     = {full_colour[23:16], full_colour[15:8], full_colour[7:0]};
    assign pix_alpha   = (bpp == BPP_4) ? s_data_byte : ALPHA_OPAQUE;

    assign cfg_hit = cfg_wr_en && ((cfg_index == CFG_IMAGE_TYPE) ||
                                   (cfg_index == CFG_PIXEL_DEPTH) ||
                                   (cfg_index == CFG_PIXEL_COUNT));

    always_comb begin
        image_type_next    = image_type_reg;
        pixel_depth_next   = pixel_depth_reg;
        pixel_count_next   = pixel_count_reg;
        expect_header_next = expect_header_reg;
        run_packet_next    = run_packet_reg;
        packet_left_next   = packet_left_reg;
        byte_pos_next      = byte_pos_reg;
        colour_next        = colour_reg;
        pixels_left_next   = pixels_left_reg;

        if (cfg_hit) begin
            case (cfg_index)
                CFG_IMAGE_TYPE:  image_type_next  = cfg_wr_data[7:0];
                CFG_PIXEL_DEPTH: pixel_depth_next = cfg_wr_data[7:0];
                CFG_PIXEL_COUNT: pixel_count_next = cfg_wr_data;
                default: ;
            endcase
            // any register write restarts the image; palette survives
            expect_header_next = 1'b1;
            run_packet_next    = 1'b0;
            packet_left_next   = 8'd0;
            byte_pos_next      = 2'd0;
            colour_next        = 24'd0;
            pixels_left_next   = (cfg_index == CFG_PIXEL_COUNT) ? cfg_wr_data
                                                                : pixel_count_reg;
        end else if (header_byte) begin
            run_packet_next    = s_data_byte[7];
            packet_left_next   = {1'b0, s_data_byte[6:0]} + 8'd1;
            expect_header_next = 1'b0;
            byte_pos_next      = 2'd0;
            colour_next        = 24'd0;
        end else if (gather_byte) begin
            case (byte_pos_reg)
                2'd0:    colour_next[7:0]   = s_data_byte;
                2'd1:    colour_next[15:8]  = s_data_byte;
                2'd2:    colour_next[23:16] = s_data_byte;
                default: ;
            endcase
            byte_pos_next = byte_pos_reg + 2'd1;
        end else if (emit) begin
            byte_pos_next = 2'd0;
            colour_next   = 24'd0;
            if (rle && run_packet_reg) begin
                packet_left_next   = 8'd0;
                expect_header_next = 1'b1;
            end else if (rle) begin
                packet_left_next = packet_left_reg - 8'd1;
                if (packet_left_reg == 8'd1) begin
                    expect_header_next = 1'b1;
                end
            end
            pixels_left_next = pixels_left_reg - 32'(rep);
            if (last) begin
                expect_header_next = 1'b1;
                run_packet_next    = 1'b0;
                packet_left_next   = 8'd0;
            end
        end
    end

    always_comb begin
        s1_vld_next = s1_vld_reg;
        if (emit) begin
            s1_vld_next = 1'b1;
        end else if (s1_move) begin
            s1_vld_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (out_free) begin
            m_valid_next = s1_vld_reg;
        end
    end

    // Palette port: writes from palette requests, reads on every pixel byte.
    // A write and a later read of the same entry come from separate requests,
    // so the read always sees the written value.
    always_comb begin
        pal_req.wr_en    = s_accept && (s_kind == KIND_PALETTE);
        pal_req.wr_index = s_palette_index;
        pal_req.wr_value = s_palette_value;
        pal_req.rd_en    = pix_req;
        pal_req.rd_index = s_data_byte;
    end

    tpsd_palette #(
        .ENTRIES (PALETTE_ENTRIES)
    ) u_palette (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (pal_req),
        .rsp     (pal_rsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            image_type_reg    <= 8'd0;
            pixel_depth_reg   <= 8'd0;
            pixel_count_reg   <= 32'd0;
            expect_header_reg <= 1'b1;
            run_packet_reg    <= 1'b0;
            packet_left_reg   <= 8'd0;
            byte_pos_reg      <= 2'd0;
            colour_reg        <= 24'd0;
            pixels_left_reg   <= 32'd0;
            s1_vld_reg        <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            image_type_reg    <= image_type_next;
            pixel_depth_reg   <= pixel_depth_next;
            pixel_count_reg   <= pixel_count_next;
            expect_header_reg <= expect_header_next;
            run_packet_reg    <= run_packet_next;
            packet_left_reg   <= packet_left_next;
            byte_pos_reg      <= byte_pos_next;
            colour_reg        <= colour_next;
            pixels_left_reg   <= pixels_left_next;
            s1_vld_reg        <= s1_vld_next;
            m_valid_reg       <= m_valid_next;
        end
    end

    // stage 1 payload
    always_ff @(posedge aclk) begin
        if (emit) begin
            s1_use_pal_reg <= (bpp == BPP_1);
            s1_rgb_reg     <= pix_rgb;
            s1_alpha_reg   <= (bpp == BPP_1) ? ALPHA_OPAQUE : pix_alpha;
            s1_cidx_reg    <= (bpp == BPP_1) ? s_data_byte : 8'd0;
            s1_rep_reg     <= rep;
            s1_last_reg    <= last;
        end
    end

    // output payload; palette entry is blue 23:16, green 15:8, red 7:0
    always_ff @(posedge aclk) begin
        if (s1_move) begin
            if (s1_use_pal_reg) begin
                m_red_reg   <= pal_rsp.value[7:0];
                m_green_reg <= pal_rsp.value[15:8];
                m_blue_reg  <= pal_rsp.value[23:16];
            end else begin
                m_red_reg   <= s1_rgb_reg[23:16];
                m_green_reg <= s1_rgb_reg[15:8];
                m_blue_reg  <= s1_rgb_reg[7:0];
            end
            m_alpha_reg <= s1_alpha_reg;
            m_cidx_reg  <= s1_cidx_reg;
            m_rep_reg   <= s1_rep_reg;
            m_last_reg  <= s1_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_red         = m_red_reg;
    assign m_green       = m_green_reg;
    assign m_blue        = m_blue_reg;
    assign m_alpha       = m_alpha_reg;
    assign m_color_index = m_cidx_reg;
    assign m_repeat_res  = m_rep_reg;
    assign m_last_pixel  = m_last_reg;

    // ---------------- assertions ----------------
    a_stall_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_vld_reg && m_valid_reg && !m_ready) |-> !s_ready)
        else $error("request accepted while stage 1 and output are both held");

    a_repeat_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_repeat_res != 8'd0) && (m_repeat_res <= 8'd128))
        else $error("repeat count out of range");

    a_last_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (emit && last && !cfg_hit) |=> (pixels_left_reg == 32'd0))
        else $error("last pixel left pixels outstanding");

    a_done_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        (pixels_left_reg == 32'd0) |-> !emit)
        else $error("pixel emitted after the image finished");

endmodule

FILE: hw/rtl/tpsd_palette.sv
// Palette memory: synchronous read, per-entry valid bits for reset clearing.
module tpsd_palette #(
    parameter int ENTRIES = 256
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  tpsd_pkg::pal_req_t  req,
    output tpsd_pkg::pal_rsp_t  rsp
);
    import tpsd_pkg::*;

    localparam int AW = $clog2(ENTRIES);

    logic [23:0]        mem [ENTRIES];
    logic [ENTRIES-1:0] vld_reg;
    logic [23:0]        rd_data_reg;
    logic               rd_hit_reg;
    logic               wr_in_range;
    logic               rd_in_range;

    assign wr_in_range = ({1'b0, req.wr_index} < 9'(ENTRIES));
    assign rd_in_range = ({1'b0, req.rd_index} < 9'(ENTRIES));

    always_ff @(posedge aclk) begin
        if (req.wr_en && wr_in_range) begin
            mem[req.wr_index[AW-1:0]] <= req.wr_value;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (req.wr_en && wr_in_range) begin
            vld_reg[req.wr_index[AW-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (req.rd_en) begin
            rd_data_reg <= mem[req.rd_index[AW-1:0]];
            rd_hit_reg  <= rd_in_range && vld_reg[req.rd_index[AW-1:0]];
        end
    end

    assign rsp.value = rd_hit_reg ? rd_data_reg : 24'd0;

endmodule
